// ===== hw/rtl/ptom_pkg.sv =====
// Shared types, codes and constants of the price-time order matcher.
package ptom_pkg;

  localparam int unsigned OrderSlotsDefault = 32;

  typedef enum logic [1:0] {
    REQ_NEW     = 2'd0,
    REQ_CANCEL  = 2'd1,
    REQ_REPLACE = 2'd2,
    REQ_UNSUP   = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    EV_ACCEPTED  = 3'd0,
    EV_REJECTED  = 3'd1,
    EV_TRADE     = 3'd2,
    EV_FILLED    = 3'd3,
    EV_PARTIAL   = 3'd4,
    EV_RESTED    = 3'd5,
    EV_CANCELLED = 3'd6
  } event_kind_e;

  typedef enum logic [3:0] {
    RJ_NONE     = 4'd0,
    RJ_UNSUP    = 4'd1,
    RJ_SIDE     = 4'd2,
    RJ_PRICE    = 4'd3,
    RJ_QTY      = 4'd4,
    RJ_DUP      = 4'd5,
    RJ_INSTR    = 4'd6,
    RJ_TIF      = 4'd7,
    RJ_UNKNOWN  = 4'd8,
    RJ_BADREPL  = 4'd9,
    RJ_REPLDUP  = 4'd10,
    RJ_FULL     = 4'd11
  } reject_code_e;

  localparam logic CFG_EVENT_SEQ_START = 1'b0;
  localparam logic CFG_TRADE_ID_START  = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] ord_id;
    logic [63:0] replacement_id;
    logic [1:0]  side_code;
    logic signed [31:0] limit_price;
    logic signed [31:0] order_quantity;
    logic [31:0] instrument;
    logic [7:0]  validity_code;
  } req_t;

  typedef struct packed {
    logic [63:0] event_seq;
    logic [63:0] event_order_id;
    logic [63:0] contra_id;
    logic [63:0] trade_number;
    logic signed [31:0] event_price;
    logic [30:0] event_quantity;
    logic [30:0] left_quantity;
    logic [31:0] event_instrument;
    logic [2:0]  event_kind;
    logic [1:0]  event_side;
    logic [3:0]  reject_code;
    logic        last_event;
  } evt_t;

  typedef struct packed {
    logic        index;
    logic [63:0] data;
  } cfg_t;

  // Resting order record held in the slot memory.
  typedef struct packed {
    logic [63:0] ord_id;
    logic        is_sell;
    logic signed [31:0] price;
    logic [30:0] remaining;
    logic [31:0] instrument;
    logic [31:0] arrival;
  } slot_t;

endpackage

// ===== hw/rtl/ptom_if.sv =====
// Valid/ready channel interfaces for requests, events and configuration.
interface ptom_req_if import ptom_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ptom_evt_if import ptom_pkg::*; ();
  logic valid;
  logic ready;
  evt_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ptom_cfg_if import ptom_pkg::*; ();
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ptom_slot_mem.sv =====
// Slot memory of resting orders: one write port, one registered read port.
module ptom_slot_mem import ptom_pkg::*; #(
  parameter int unsigned Slots = OrderSlotsDefault,
  localparam int unsigned IdxW = (Slots > 1) ? $clog2(Slots) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  slot_t           wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output slot_t           rdata_o
);

  slot_t mem_q [Slots];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/price_time_order_matcher_core.sv =====
// Top level: order book sequencer around the slot memory.
// A request is accepted, then its lookup scan (id, replacement id and free slot) runs,
// then a match scan per trade and one more that finds no contra (none once the order
// has filled). One request at a time; the block waits on each event until the sink
// takes it.
// Reset clears valid bits, counters and the bound instrument; no memory sweep.
module price_time_order_matcher_core import ptom_pkg::*; #(
  parameter int unsigned OrderSlots = OrderSlotsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  ptom_req_if.sink   req,
  ptom_evt_if.source evt,
  ptom_cfg_if.sink   cfg
);

  localparam int unsigned IdxW = (OrderSlots > 1) ? $clog2(OrderSlots) : 1;
  localparam int unsigned CntW = $clog2(OrderSlots + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_DECIDE, ST_CANCEL, ST_ACCEPT, ST_MATCH,
    ST_MATCH_DONE, ST_TRADE, ST_FINISH, ST_EMIT
  } state_e;

  state_e state_q, ret_q;
  req_t   r_q;
  logic [OrderSlots-1:0] valid_q;
  logic [31:0] arrival_q;
  logic [63:0] seq_q, trade_q;
  logic        bound_q;
  logic [31:0] bound_instr_q;

  // Scan state
  logic [CntW-1:0] cnt_q;
  logic            rd_v_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            hit_o_q, hit_r_q, free_v_q, best_v_q;
  logic [IdxW-1:0] hit_o_idx_q, free_idx_q, best_idx_q;
  slot_t           hit_o_q_s, best_q;
  logic            match_mode_q;   // scan looks for best contra
  logic            repl_q;         // second phase of replace
  logic [63:0]     oid_q;
  logic [30:0]     rem_q, qty_q;
  logic            sell_q;

  evt_t  out_q;
  logic  out_v_q;

  // Memory
  logic            we;
  logic [IdxW-1:0] waddr;
  slot_t           wdata, rdata;
  logic [IdxW-1:0] raddr;

  assign raddr = cnt_q[IdxW-1:0];

  ptom_slot_mem #(.Slots(OrderSlots)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign req.ready = (state_q == ST_IDLE);
  assign cfg.ready = (state_q == ST_IDLE);
  assign evt.valid = out_v_q;
  assign evt.data  = out_q;

  // Candidate comparison for the best crossing opposite order.
  logic cand_ok, cand_better;
  logic [31:0] age_c, age_b;
  always_comb begin
    age_c = arrival_q - rdata.arrival;
    age_b = arrival_q - best_q.arrival;
    cand_ok = rd_v_q && valid_q[rd_idx_q] && (rdata.is_sell != sell_q) &&
              (sell_q ? (rdata.price >= r_q.limit_price)
                      : (rdata.price <= r_q.limit_price));
    if (!best_v_q) begin
      cand_better = 1'b1;
    end else if (rdata.price != best_q.price) begin
      cand_better = sell_q ? (rdata.price > best_q.price) : (rdata.price < best_q.price);
    end else begin
      cand_better = age_c > age_b;
    end
  end

  // Request checks after the lookup scan.
  logic [3:0] rej;
  logic [30:0] qty31;
  assign qty31 = r_q.order_quantity[30:0];
  always_comb begin
    rej = RJ_NONE;
    if (!repl_q && r_q.req_type == REQ_CANCEL) begin
      if (!hit_o_q) rej = RJ_UNKNOWN;
      else if (hit_o_q_s.instrument != r_q.instrument) rej = RJ_INSTR;
    end else if (!repl_q && r_q.req_type == REQ_REPLACE) begin
      if (!hit_o_q) rej = RJ_UNKNOWN;
      else if (hit_o_q_s.instrument != r_q.instrument) rej = RJ_INSTR;
      else if (r_q.replacement_id == '0 || r_q.replacement_id == r_q.ord_id)
        rej = RJ_BADREPL;
      else if (hit_r_q) rej = RJ_REPLDUP;
      else if (r_q.side_code > 2'd1) rej = RJ_SIDE;
      else if (r_q.limit_price <= 0) rej = RJ_PRICE;
      else if (r_q.order_quantity <= 0) rej = RJ_QTY;
      else if (r_q.validity_code != 8'd0) rej = RJ_TIF;
    end else if (!repl_q && r_q.req_type == REQ_UNSUP) begin
      rej = RJ_UNSUP;
    end else begin
      if (r_q.side_code > 2'd1) rej = RJ_SIDE;
      else if (r_q.limit_price <= 0) rej = RJ_PRICE;
      else if (r_q.order_quantity <= 0) rej = RJ_QTY;
      else if (repl_q ? hit_r_q : hit_o_q) rej = RJ_DUP;
      else if (bound_q && r_q.instrument != bound_instr_q) rej = RJ_INSTR;
      else if (r_q.validity_code != 8'd0) rej = RJ_TIF;
      else if (!free_v_q) rej = RJ_FULL;
    end
  end

  logic [30:0] tq;
  assign tq = (rem_q < best_q.remaining) ? rem_q : best_q.remaining;

  function automatic evt_t mk(logic [63:0] oid, logic signed [31:0] pr,
                              logic [30:0] q, logic [30:0] l, logic [31:0] ins,
                              logic [2:0] k, logic [1:0] sd, logic [3:0] rc,
                              logic lst);
    evt_t e;
    e = '0;
    e.event_order_id = oid; e.event_price = pr; e.event_quantity = q;
    e.left_quantity = l; e.event_instrument = ins; e.event_kind = k;
    e.event_side = sd; e.reject_code = rc; e.last_event = lst;
    return e;
  endfunction

  // Trade event against the best contra order.
  evt_t trade_ev;
  always_comb begin
    trade_ev = mk(oid_q, best_q.price, tq, rem_q - tq, r_q.instrument,
                  EV_TRADE, r_q.side_code, RJ_NONE, 1'b0);
    trade_ev.contra_id = best_q.ord_id;
    trade_ev.trade_number = trade_q;
  end

  always_comb begin
    we = 1'b0;
    waddr = best_idx_q;
    wdata = best_q;
    if (state_q == ST_TRADE) begin
      we = 1'b1;
      wdata.remaining = best_q.remaining - tq;
    end else if (state_q == ST_FINISH && rem_q != '0) begin
      we = 1'b1;
      waddr = free_idx_q;
      wdata.ord_id = oid_q; wdata.is_sell = sell_q;
      wdata.price = r_q.limit_price; wdata.remaining = rem_q;
      wdata.instrument = r_q.instrument; wdata.arrival = arrival_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; ret_q <= ST_IDLE;
      valid_q <= '0; arrival_q <= '0; seq_q <= '0; trade_q <= 64'd1;
      bound_q <= 1'b0; bound_instr_q <= '0; out_v_q <= 1'b0;
      cnt_q <= '0; rd_v_q <= 1'b0; repl_q <= 1'b0; match_mode_q <= 1'b0;
      hit_o_q <= 1'b0; hit_r_q <= 1'b0; free_v_q <= 1'b0; best_v_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cfg.valid) begin
            if (cfg.data.index == CFG_EVENT_SEQ_START) seq_q <= cfg.data.data;
            else trade_q <= cfg.data.data;
          end
          if (req.valid) begin
            r_q <= req.data;
            oid_q <= req.data.ord_id;
            sell_q <= (req.data.side_code == 2'd1);
            repl_q <= 1'b0; match_mode_q <= 1'b0;
            hit_o_q <= 1'b0; hit_r_q <= 1'b0; free_v_q <= 1'b0;
            cnt_q <= '0; rd_v_q <= 1'b0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Address cnt_q is read now; the previous one is in rdata.
          rd_v_q <= (cnt_q < CntW'(OrderSlots));
          rd_idx_q <= raddr;
          if (cnt_q < CntW'(OrderSlots)) cnt_q <= cnt_q + 1'b1;
          if (rd_v_q) begin
            if (match_mode_q) begin
              if (cand_ok && cand_better) begin
                best_v_q <= 1'b1; best_idx_q <= rd_idx_q; best_q <= rdata;
              end
            end else begin
              if (valid_q[rd_idx_q] && rdata.ord_id == r_q.ord_id) begin
                hit_o_q <= 1'b1; hit_o_idx_q <= rd_idx_q; hit_o_q_s <= rdata;
              end
              if (valid_q[rd_idx_q] && rdata.ord_id == r_q.replacement_id)
                hit_r_q <= 1'b1;
            end
          end
          if (!match_mode_q && !valid_q[raddr] && !free_v_q &&
              cnt_q < CntW'(OrderSlots)) begin
            free_v_q <= 1'b1; free_idx_q <= raddr;
          end
          if (!(cnt_q < CntW'(OrderSlots)) && !rd_v_q)
            state_q <= match_mode_q ? ST_MATCH_DONE : ST_DECIDE;
        end
        ST_DECIDE: begin
          if (rej != RJ_NONE) begin
            out_q <= mk(oid_q, r_q.limit_price, '0, '0, r_q.instrument,
                        EV_REJECTED, r_q.side_code, rej, 1'b1);
            ret_q <= ST_IDLE; state_q <= ST_EMIT;
          end else if (!repl_q && (r_q.req_type == REQ_CANCEL ||
                                   r_q.req_type == REQ_REPLACE)) begin
            state_q <= ST_CANCEL;
          end else begin
            state_q <= ST_ACCEPT;
          end
        end
        ST_CANCEL: begin
          valid_q[hit_o_idx_q] <= 1'b0;
          out_q <= mk(oid_q, hit_o_q_s.price, '0, hit_o_q_s.remaining,
                      hit_o_q_s.instrument, EV_CANCELLED,
                      {1'b0, hit_o_q_s.is_sell}, RJ_NONE,
                      r_q.req_type == REQ_CANCEL);
          if (r_q.req_type == REQ_CANCEL) begin
            ret_q <= ST_IDLE;
          end else begin
            // The freed slot serves the replacement order.
            repl_q <= 1'b1; oid_q <= r_q.replacement_id;
            free_v_q <= 1'b1; free_idx_q <= hit_o_idx_q;
            ret_q <= ST_ACCEPT;
          end
          state_q <= ST_EMIT;
        end
        ST_ACCEPT: begin
          if (repl_q && rej != RJ_NONE) begin
            out_q <= mk(oid_q, r_q.limit_price, '0, '0, r_q.instrument,
                        EV_REJECTED, r_q.side_code, rej, 1'b1);
            ret_q <= ST_IDLE;
          end else begin
            if (!bound_q) begin
              bound_q <= 1'b1; bound_instr_q <= r_q.instrument;
            end
            qty_q <= qty31; rem_q <= qty31;
            out_q <= mk(oid_q, r_q.limit_price, qty31, qty31, r_q.instrument,
                        EV_ACCEPTED, r_q.side_code, RJ_NONE, 1'b0);
            ret_q <= ST_MATCH;
          end
          state_q <= ST_EMIT;
        end
        ST_MATCH: begin
          if (rem_q == '0) begin
            state_q <= ST_FINISH;
          end else begin
            match_mode_q <= 1'b1; best_v_q <= 1'b0;
            cnt_q <= '0; rd_v_q <= 1'b0; state_q <= ST_SCAN;
          end
        end
        ST_MATCH_DONE: begin
          state_q <= best_v_q ? ST_TRADE : ST_FINISH;
        end
        ST_TRADE: begin
          rem_q <= rem_q - tq;
          if (best_q.remaining == tq) valid_q[best_idx_q] <= 1'b0;
          out_q <= trade_ev;
          trade_q <= trade_q + 64'd1;
          ret_q <= ST_MATCH; state_q <= ST_EMIT;
        end
        ST_FINISH: begin
          // The free slot found at lookup is still free: matching only frees.
          if (rem_q == '0) begin
            out_q <= mk(oid_q, r_q.limit_price, qty_q, '0, r_q.instrument,
                        EV_FILLED, r_q.side_code, RJ_NONE, 1'b1);
          end else begin
            valid_q[free_idx_q] <= 1'b1;
            arrival_q <= arrival_q + 32'd1;
            out_q <= mk(oid_q, r_q.limit_price, qty_q - rem_q, rem_q,
                        r_q.instrument,
                        (rem_q != qty_q) ? EV_PARTIAL : EV_RESTED,
                        r_q.side_code, RJ_NONE, 1'b1);
          end
          ret_q <= ST_IDLE; state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_v_q) begin
            out_v_q <= 1'b1;
            out_q.event_seq <= seq_q;
            seq_q <= seq_q + 64'd1;
          end else if (evt.ready) begin
            out_v_q <= 1'b0;
            state_q <= ret_q;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !evt.ready) |=> (out_v_q && $stable(out_q)))
    else $error("event changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.ready |-> !out_v_q)
    else $error("request taken while an event is pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TRADE) |-> (best_v_q && tq != '0))
    else $error("trade without a contra order");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && evt.ready) |=> (seq_q == $past(seq_q)))
    else $error("sequence moved at delivery");

endmodule

// ===== tb/ptom_tb_checker.sv =====
// Book predictor and event scoreboard for the price-time order matcher.
module ptom_tb_checker import ptom_pkg::*; #(
  parameter int unsigned Slots = OrderSlotsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  logic req_ready_i,
  input  req_t req_data_i,
  input  logic evt_valid_i,
  input  logic evt_ready_i,
  input  evt_t evt_data_i,
  input  logic cfg_valid_i,
  input  logic cfg_ready_i,
  input  cfg_t cfg_data_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   events_seen_o,
  output int   trades_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic        book_live[Slots];
  logic [63:0] book_id[Slots];
  logic        book_sell[Slots];
  logic signed [31:0] book_px[Slots];
  logic [30:0] book_left[Slots];
  logic [31:0] book_instr[Slots];
  logic [31:0] book_arrival[Slots];
  logic [31:0] arrival_ctr;
  logic [63:0] seq_ctr;
  logic [63:0] trade_ctr;
  logic        instr_bound;
  logic [31:0] instr_value;

  evt_t expected_events[$];
  int   fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = expected_events.size();

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fail_count++;
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  function automatic int find_id(input logic [63:0] id);
    for (int i = 0; i < Slots; i++)
      if (book_live[i] && book_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int find_free();
    for (int i = 0; i < Slots; i++)
      if (!book_live[i]) return i;
    return -1;
  endfunction

  function automatic void push_event(input logic [63:0] oid, input logic [63:0] contra,
      input logic [63:0] tno, input logic signed [31:0] px, input logic [30:0] qty,
      input logic [30:0] left, input logic [31:0] instr, input event_kind_e kind,
      input logic [1:0] side, input reject_code_e rj);
    evt_t e;
    e.event_seq = seq_ctr;
    seq_ctr++;
    e.event_order_id = oid;
    e.contra_id = contra;
    e.trade_number = tno;
    e.event_price = px;
    e.event_quantity = qty;
    e.left_quantity = left;
    e.event_instrument = instr;
    e.event_kind = kind;
    e.event_side = side;
    e.reject_code = rj;
    e.last_event = 1'b0;
    expected_events.insert(expected_events.size(), e);
  endfunction

  function automatic void enter_order(input logic [63:0] oid, input logic [1:0] side,
      input logic signed [31:0] px, input logic signed [31:0] qty,
      input logic [31:0] instr, input logic [7:0] tif);
    reject_code_e rj;
    logic sell;
    logic [30:0] rem;
    int best;
    int s;
    logic [30:0] tq;
    rj = RJ_NONE;
    sell = (side == 2'd1);
    if (side > 2'd1) rj = RJ_SIDE;
    else if (px <= 0) rj = RJ_PRICE;
    else if (qty <= 0) rj = RJ_QTY;
    else if (find_id(oid) >= 0) rj = RJ_DUP;
    else if (instr_bound && instr != instr_value) rj = RJ_INSTR;
    else if (tif != 8'd0) rj = RJ_TIF;
    else if (find_free() < 0) rj = RJ_FULL;
    if (rj != RJ_NONE) begin
      push_event(oid, 0, 0, px, 0, 0, instr, EV_REJECTED, side, rj);
      return;
    end
    if (!instr_bound) begin
      instr_bound = 1'b1;
      instr_value = instr;
    end
    rem = qty[30:0];
    push_event(oid, 0, 0, px, rem, rem, instr, EV_ACCEPTED, side, RJ_NONE);
    while (rem > 0) begin
      best = -1;
      for (int i = 0; i < Slots; i++) begin
        if (!book_live[i] || book_sell[i] == sell) continue;
        if (sell ? book_px[i] < px : book_px[i] > px) continue;
        if (best < 0) best = i;
        else if (book_px[i] != book_px[best]) begin
          if (sell ? book_px[i] > book_px[best] : book_px[i] < book_px[best]) best = i;
        end else if (32'(arrival_ctr - book_arrival[i]) >
                     32'(arrival_ctr - book_arrival[best])) begin
          best = i;
        end
      end
      if (best < 0) break;
      tq = rem < book_left[best] ? rem : book_left[best];
      rem -= tq;
      book_left[best] -= tq;
      push_event(oid, book_id[best], trade_ctr, book_px[best], tq, rem, instr,
                 EV_TRADE, side, RJ_NONE);
      trade_ctr++;
      if (book_left[best] == 0) book_live[best] = 1'b0;
    end
    if (rem == 0) begin
      push_event(oid, 0, 0, px, qty[30:0], 0, instr, EV_FILLED, side, RJ_NONE);
      return;
    end
    s = find_free();
    if (s >= 0) begin
      book_live[s] = 1'b1;
      book_id[s] = oid;
      book_sell[s] = sell;
      book_px[s] = px;
      book_left[s] = rem;
      book_instr[s] = instr;
      book_arrival[s] = arrival_ctr;
      arrival_ctr++;
    end
    push_event(oid, 0, 0, px, qty[30:0] - rem, rem, instr,
               rem != qty[30:0] ? EV_PARTIAL : EV_RESTED, side, RJ_NONE);
  endfunction

  function automatic void cancel_slot(input logic [63:0] oid, input int s);
    book_live[s] = 1'b0;
    push_event(oid, 0, 0, book_px[s], 0, book_left[s], book_instr[s], EV_CANCELLED,
               {1'b0, book_sell[s]}, RJ_NONE);
  endfunction

  function automatic void predict_request(input req_t r);
    int s;
    int before_n;
    reject_code_e rj;
    before_n = expected_events.size();
    rj = RJ_NONE;
    s = find_id(r.ord_id);
    case (req_type_e'(r.req_type))
      REQ_NEW: begin
        enter_order(r.ord_id, r.side_code, r.limit_price, r.order_quantity,
                    r.instrument, r.validity_code);
      end
      REQ_CANCEL: begin
        if (s < 0) rj = RJ_UNKNOWN;
        else if (book_instr[s] != r.instrument) rj = RJ_INSTR;
        if (rj != RJ_NONE)
          push_event(r.ord_id, 0, 0, r.limit_price, 0, 0, r.instrument, EV_REJECTED,
                     r.side_code, rj);
        else cancel_slot(r.ord_id, s);
      end
      REQ_REPLACE: begin
        if (s < 0) rj = RJ_UNKNOWN;
        else if (book_instr[s] != r.instrument) rj = RJ_INSTR;
        else if (r.replacement_id == 0 || r.replacement_id == r.ord_id) rj = RJ_BADREPL;
        else if (find_id(r.replacement_id) >= 0) rj = RJ_REPLDUP;
        else if (r.side_code > 2'd1) rj = RJ_SIDE;
        else if (r.limit_price <= 0) rj = RJ_PRICE;
        else if (r.order_quantity <= 0) rj = RJ_QTY;
        else if (r.validity_code != 8'd0) rj = RJ_TIF;
        if (rj != RJ_NONE)
          push_event(r.ord_id, 0, 0, r.limit_price, 0, 0, r.instrument, EV_REJECTED,
                     r.side_code, rj);
        else begin
          cancel_slot(r.ord_id, s);
          enter_order(r.replacement_id, r.side_code, r.limit_price, r.order_quantity,
                      r.instrument, r.validity_code);
        end
      end
      default: begin
        push_event(r.ord_id, 0, 0, r.limit_price, 0, 0, r.instrument, EV_REJECTED,
                   r.side_code, RJ_UNSUP);
      end
    endcase
    if (expected_events.size() > before_n)
      expected_events[expected_events.size() - 1].last_event = 1'b1;
  endfunction

  task automatic compare_event(input evt_t got);
    evt_t want;
    if (expected_events.size() == 0) begin
      report_mismatch("unexpected event seq", got.event_seq, 0);
      return;
    end
    want = expected_events[0];
    expected_events.delete(0);
    if (got.event_seq !== want.event_seq) report_mismatch("event_seq", got.event_seq,
                                                          want.event_seq);
    if (got.event_order_id !== want.event_order_id)
      report_mismatch("event_order_id", got.event_order_id, want.event_order_id);
    if (got.contra_id !== want.contra_id)
      report_mismatch("contra_id", got.contra_id, want.contra_id);
    if (got.trade_number !== want.trade_number)
      report_mismatch("trade_number", got.trade_number, want.trade_number);
    if (got.event_price !== want.event_price)
      report_mismatch("event_price", 64'(got.event_price), 64'(want.event_price));
    if (got.event_quantity !== want.event_quantity)
      report_mismatch("event_quantity", 64'(got.event_quantity), 64'(want.event_quantity));
    if (got.left_quantity !== want.left_quantity)
      report_mismatch("left_quantity", 64'(got.left_quantity), 64'(want.left_quantity));
    if (got.event_instrument !== want.event_instrument)
      report_mismatch("event_instrument", 64'(got.event_instrument),
                      64'(want.event_instrument));
    if (got.event_kind !== want.event_kind)
      report_mismatch("event_kind", 64'(got.event_kind), 64'(want.event_kind));
    if (got.event_side !== want.event_side)
      report_mismatch("event_side", 64'(got.event_side), 64'(want.event_side));
    if (got.reject_code !== want.reject_code)
      report_mismatch("reject_code", 64'(got.reject_code), 64'(want.reject_code));
    if (got.last_event !== want.last_event)
      report_mismatch("last_event", 64'(got.last_event), 64'(want.last_event));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) book_live[i] = 1'b0;
      arrival_ctr   = '0;
      seq_ctr       = 64'd0;
      trade_ctr     = 64'd1;
      instr_bound   = 1'b0;
      instr_value   = '0;
      fail_count    = 0;
      events_seen_o <= 0;
      trades_seen_o <= 0;
      expected_events.delete();
    end else begin
      // Events are compared first; a request accepted in the same cycle cannot
      // have produced any of them yet.
      if (evt_valid_i && evt_ready_i) begin
        compare_event(evt_data_i);
        events_seen_o <= events_seen_o + 1;
        if (evt_data_i.event_kind == EV_TRADE) trades_seen_o <= trades_seen_o + 1;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_data_i.index == CFG_EVENT_SEQ_START) seq_ctr = cfg_data_i.data;
        else trade_ctr = cfg_data_i.data;
      end
      if (req_valid_i && req_ready_i) predict_request(req_data_i);
    end
  end

endmodule

// ===== tb/tb_price_time_order_matcher_core.sv =====
// Top of the order matcher testbench: clock, reset, stimulus and verdict.
module tb_price_time_order_matcher_core;
  import ptom_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots = OrderSlotsDefault;
  localparam int unsigned RandomRequests = 252;
  localparam int unsigned HoldCycles = 600;
  localparam longint unsigned CycleLimit = 2_000_000;
  localparam logic [31:0] BookInstr = 32'h0000_1234;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   events_seen;
  int   trades_seen;
  int   requests_sent;
  longint unsigned cycle_count;
  logic hold_off;
  logic stim_done;

  logic [63:0] live_ids[$];
  logic [63:0] next_id;

  ptom_req_if req_ch ();
  ptom_evt_if evt_ch ();
  ptom_cfg_if cfg_ch ();

  price_time_order_matcher_core #(.OrderSlots(Slots)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req_ch.sink),
    .evt   (evt_ch.source),
    .cfg   (cfg_ch.sink)
  );

  ptom_tb_checker #(.Slots(Slots)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_ch.valid),
    .req_ready_i  (req_ch.ready),
    .req_data_i   (req_ch.data),
    .evt_valid_i  (evt_ch.valid),
    .evt_ready_i  (evt_ch.ready),
    .evt_data_i   (evt_ch.data),
    .cfg_valid_i  (cfg_ch.valid),
    .cfg_ready_i  (cfg_ch.ready),
    .cfg_data_i   (cfg_ch.data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .events_seen_o(events_seen),
    .trades_seen_o(trades_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Event sink: random stall per beat, plus one long hold-off on request.
  initial begin
    int gap;
    evt_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        // The stall is timed here so the block backs up into its request side.
        evt_ch.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_off = 1'b0;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
          evt_ch.ready <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        evt_ch.ready <= 1'b1;
        do @(posedge clk_i); while (!evt_ch.valid);
      end
    end
  end

  task automatic send_request(input req_t r, input bit no_gaps);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    @(negedge clk_i);
    repeat (gap) @(negedge clk_i);
    req_ch.data  <= r;
    req_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    requests_sent++;
  endtask

  task automatic write_register(input logic idx, input logic [63:0] value);
    @(negedge clk_i);
    cfg_ch.data  <= '{index: idx, data: value};
    cfg_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain_events();
    while (pending != 0) @(posedge clk_i);
    repeat (4 * (Slots + 2)) @(posedge clk_i);
  endtask

  function automatic req_t make_request(input req_type_e kind, input logic [63:0] oid,
      input logic [63:0] rid, input logic [1:0] side, input logic signed [31:0] px,
      input logic signed [31:0] qty, input logic [31:0] instr, input logic [7:0] tif);
    req_t r;
    r.req_type = kind;
    r.ord_id = oid;
    r.replacement_id = rid;
    r.side_code = side;
    r.limit_price = px;
    r.order_quantity = qty;
    r.instrument = instr;
    r.validity_code = tif;
    return r;
  endfunction

  function automatic logic [63:0] pick_live_id();
    if (live_ids.size() == 0 || $urandom_range(0, 5) == 0)
      return {$urandom, $urandom};
    return live_ids[$urandom_range(0, live_ids.size() - 1)];
  endfunction

  // Mostly well-formed book traffic around a narrow price band so orders cross.
  function automatic req_t random_request();
    req_t r;
    int pick;
    logic [63:0] oid;
    pick = $urandom_range(0, 99);
    r = make_request(REQ_NEW, 0, 0, 2'($urandom_range(0, 1)),
                     32'(100 + $urandom_range(0, 8)), 32'($urandom_range(1, 40)),
                     BookInstr, 8'd0);
    if (pick < 60) begin
      oid = next_id;
      next_id++;
      r.ord_id = oid;
      live_ids.insert(live_ids.size(), oid);
      if ($urandom_range(0, 19) == 0) r.order_quantity = 32'($urandom_range(200, 400));
    end else if (pick < 72) begin
      r.req_type = REQ_CANCEL;
      r.ord_id = pick_live_id();
    end else if (pick < 84) begin
      r.req_type = REQ_REPLACE;
      r.ord_id = pick_live_id();
      r.replacement_id = next_id;
      live_ids.insert(live_ids.size(), next_id);
      next_id++;
    end else begin
      // Noise: random fields across their whole width.
      r = make_request(req_type_e'($urandom_range(0, 3)), pick_live_id(),
                       {$urandom, $urandom}, 2'($urandom_range(0, 3)), $urandom,
                       $urandom, ($urandom_range(0, 1) ? BookInstr : $urandom),
                       ($urandom_range(0, 1) ? 8'd0 : 8'($urandom)));
      if ($urandom_range(0, 3) == 0) r.replacement_id = 0;
    end
    if (live_ids.size() > 64) live_ids.delete(0);
    return r;
  endfunction

  initial begin
    req_t r;
    logic [63:0] seq_starts[4];
    logic [63:0] trade_starts[4];
    hold_off = 1'b0;
    stim_done = 1'b0;
    requests_sent = 0;
    next_id = 64'd1000;
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: every reject kind but a full book, crossing, fill, partial, cancel, replace.
    write_register(CFG_EVENT_SEQ_START, 64'hFFFF_FFFF_FFFF_FFFE);
    write_register(CFG_TRADE_ID_START, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(make_request(REQ_UNSUP, '1, '1, 2'd3, 32'sh8000_0000, 32'sh7FFF_FFFF,
                              '1, 8'hFF), 0);
    send_request(make_request(REQ_NEW, 1, 0, 2'd2, 10, 5, BookInstr, 0), 0);
    send_request(make_request(REQ_NEW, 1, 0, 2'd0, 0, 5, BookInstr, 0), 0);
    send_request(make_request(REQ_NEW, 1, 0, 2'd0, 10, 32'sh8000_0000, BookInstr, 0), 0);
    send_request(make_request(REQ_NEW, 1, 0, 2'd0, 10, 5, BookInstr, 8'd1), 0);
    send_request(make_request(REQ_NEW, 1, 0, 2'd0, 10, 5, BookInstr, 0), 0);
    send_request(make_request(REQ_NEW, 1, 0, 2'd0, 10, 5, BookInstr, 0), 0);
    send_request(make_request(REQ_NEW, 2, 0, 2'd0, 10, 5, 32'hFFFF_FFFF, 0), 0);
    send_request(make_request(REQ_NEW, 3, 0, 2'd0, 12, 7, BookInstr, 0), 0);
    send_request(make_request(REQ_NEW, 4, 0, 2'd1, 9, 20, BookInstr, 0), 0);
    send_request(make_request(REQ_NEW, 5, 0, 2'd0, 32'sh7FFF_FFFF, 3, BookInstr, 0), 0);
    send_request(make_request(REQ_NEW, 6, 0, 2'd0, 9, 32'sh7FFF_FFFF, BookInstr, 0), 0);
    send_request(make_request(REQ_CANCEL, 77, 0, 2'd0, 1, 1, BookInstr, 0), 0);
    send_request(make_request(REQ_CANCEL, 6, 0, 2'd0, 1, 1, 32'd0, 0), 0);
    send_request(make_request(REQ_REPLACE, 6, 0, 2'd0, 1, 1, BookInstr, 0), 0);
    send_request(make_request(REQ_REPLACE, 6, 6, 2'd0, 1, 1, BookInstr, 0), 0);
    send_request(make_request(REQ_NEW, 8, 0, 2'd1, 50, 4, BookInstr, 0), 0);
    send_request(make_request(REQ_REPLACE, 6, 8, 2'd0, 1, 1, BookInstr, 0), 0);
    send_request(make_request(REQ_REPLACE, 6, 9, 2'd3, 1, 1, BookInstr, 0), 0);
    send_request(make_request(REQ_REPLACE, 6, 9, 2'd0, -1, 1, BookInstr, 0), 0);
    send_request(make_request(REQ_REPLACE, 6, 9, 2'd0, 1, 0, BookInstr, 0), 0);
    send_request(make_request(REQ_REPLACE, 6, 9, 2'd0, 1, 1, BookInstr, 8'h80), 0);
    send_request(make_request(REQ_REPLACE, 6, 64'hFFFF_FFFF_FFFF_FFFF, 2'd1, 60, 9,
                              BookInstr, 0), 0);
    send_request(make_request(REQ_CANCEL, 8, 0, 2'd0, 1, 1, BookInstr, 0), 0);
    drain_events();

    // Fill the book with non-crossing buys, then provoke the full reject and
    // one sell that sweeps every resting buy.
    write_register(CFG_EVENT_SEQ_START, 64'd0);
    write_register(CFG_TRADE_ID_START, 64'd0);
    for (int i = 0; i < Slots + 1; i++)
      send_request(make_request(REQ_NEW, 64'd500 + i, 0, 2'd0, 32'(20 + (i % 3)), 2,
                                BookInstr, 0), 1);
    send_request(make_request(REQ_NEW, 64'd600, 0, 2'd1, 1, 32'sh7FFF_FFFF,
                              BookInstr, 0), 0);
    send_request(make_request(REQ_CANCEL, 64'd600, 0, 2'd1, 1, 1, BookInstr, 0), 0);
    drain_events();

    // Random phases across several counter settings.
    seq_starts   = '{64'd17, 64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0};
    trade_starts = '{64'hFFFF_FFFF_FFFF_FFF0, 64'd1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF};
    for (int ph = 0; ph < 4; ph++) begin
      write_register(CFG_EVENT_SEQ_START, seq_starts[ph]);
      write_register(CFG_TRADE_ID_START, trade_starts[ph]);
      for (int n = 0; n < RandomRequests / 4; n++) begin
        if (ph == 1 && n == 10) hold_off = 1'b1;
        r = random_request();
        send_request(r, (ph == 2) && (n < 20));
      end
      drain_events();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    drain_events();
    $display("covered %0d requests, %0d events, %0d trades, counter wrap and full book",
             requests_sent, events_seen, trades_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d events still expected", fail_count, pending);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== price_time_order_matcher_core.f =====
hw/rtl/ptom_pkg.sv
hw/rtl/ptom_if.sv
hw/rtl/ptom_slot_mem.sv
hw/rtl/price_time_order_matcher_core.sv
tb/ptom_tb_checker.sv
tb/tb_price_time_order_matcher_core.sv
